// ===== design/md5_pkg.sv =====
// Package for the MD5 digest block: word types, initial chaining values,
// the per-round sine and rotation tables, and the round helper functions.
// Depends on nothing; imported by the channel interfaces and the top level.
package md5_pkg;

  localparam int unsigned COUNT_W = 61;

  typedef logic [31:0]        word_t;
  typedef logic [7:0]         byte_t;
  typedef logic [5:0]         round_t;
  typedef logic [3:0]         msg_idx_t;
  typedef logic [4:0]         rot_t;
  typedef logic [1:0]         digest_idx_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam word_t INIT_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam byte_t PAD_BYTE = 8'h80;

  localparam round_t LAST_ROUND     = 6'd63;
  localparam round_t LEN_SPLIT_POS  = 6'd56;
  localparam digest_idx_t LAST_WORD = 2'd3;

  localparam word_t SINE_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam rot_t ROT_TABLE [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  function automatic word_t rotl32(word_t x, rot_t n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic msg_idx_t msg_index(round_t i);
    msg_idx_t lo;
    msg_idx_t idx;
    lo = i[3:0];
    case (i[5:4])
      2'd0: idx = lo;
      2'd1: idx = msg_idx_t'(lo * 4'd5 + 4'd1);
      2'd2: idx = msg_idx_t'(lo * 4'd3 + 4'd5);
      default: idx = msg_idx_t'(lo * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic word_t round_fn(round_t i, word_t b, word_t c, word_t d);
    word_t f;
    case (i[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

// ===== design/md5_in_if.sv =====
// Input channel of the MD5 digest block: one message byte per word.
// Depends on md5_pkg for the payload types.
interface md5_in_if;
  import md5_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  byte_present;
  logic  end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

// ===== design/md5_out_if.sv =====
// Output channel of the MD5 digest block: one chaining word per word.
// Depends on md5_pkg for the payload types.
interface md5_out_if;
  import md5_pkg::*;

  logic        valid;
  logic        ready;
  word_t       digest_word;
  digest_idx_t word_number;
  logic        final_word;

  modport source (output valid, output digest_word, output word_number,
                  output final_word, input ready);
  modport sink   (input valid, input digest_word, input word_number,
                  input final_word, output ready);
endinterface

// ===== design/md5_message_digest.sv =====
// MD5 digest of a byte stream, one shared round unit under a small sequencer.
// Depends on md5_pkg, md5_in_if and md5_out_if.
//
// Usage: each input word carries one message byte (when byte_present is set)
// and an end-of-message flag; a word with end_of_message set and no byte ends
// an empty or already complete message. After the end the block emits four
// output words, the chaining words in order 0 to 3, the last one flagged by
// final_word, and then returns to its reset state for the next message.
// An ordinary byte is taken and stored in the block buffer. Every 64th byte starts
// a block compression: the 64 MD5 steps in the single round unit, then an
// add into the chaining words, and that byte holds the input until it ends.
// At the end of a message padding takes one padding step and one compression,
// or two padding steps and two compressions (ST_PAD, then ST_LEN) when
// fewer than nine bytes of room remain in the last block. The four output
// words then follow at one a cycle while the receiver is ready; a stalled
// receiver simply holds the current word and the block waits. Input is not
// taken while a compression, padding or output is under way. Reset loads
// the standard initial chaining values and clears the byte count.
module md5_message_digest (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_e;

  state_e      state_q, state_d;
  word_t       chain_q [4];
  word_t       chain_d [4];
  word_t       work_q  [4];
  word_t       work_d  [4];
  count_t      cnt_q, cnt_d;
  round_t      rnd_q, rnd_d;
  digest_idx_t out_idx_q, out_idx_d;
  logic        end_pend_q, end_pend_d;
  logic        len_pend_q, len_pend_d;
  logic        fin_q, fin_d;

  word_t       block_q [16];
  word_t       blk_all_d [16];
  logic        blk_we_byte;
  logic        blk_we_all;

  logic        in_acc;
  logic        out_acc;
  round_t      pos;
  logic [63:0] bit_len;
  word_t       f_val;
  word_t       sum;
  word_t       new_b;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign pos     = cnt_q[5:0];
  assign bit_len = {cnt_q, 3'b000};

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.digest_word = chain_q[out_idx_q];
  assign out_o.word_number = out_idx_q;
  assign out_o.final_word  = (out_idx_q == LAST_WORD);

  // The shared round unit: one MD5 step per cycle on the working words.
  assign f_val = round_fn(rnd_q, work_q[1], work_q[2], work_q[3]);
  assign sum   = work_q[0] + f_val + SINE_TABLE[rnd_q] + block_q[msg_index(rnd_q)];
  assign new_b = work_q[1] + rotl32(sum, ROT_TABLE[rnd_q[5:4]][rnd_q[1:0]]);

  always_comb begin
    for (int w = 0; w < 16; w++) begin
      for (int l = 0; l < 4; l++) begin
        if (state_q == ST_LEN) begin
          blk_all_d[w][8*l +: 8] = '0;
        end else if (round_t'(w * 4 + l) < pos) begin
          blk_all_d[w][8*l +: 8] = block_q[w][8*l +: 8];
        end else if (round_t'(w * 4 + l) == pos) begin
          blk_all_d[w][8*l +: 8] = PAD_BYTE;
        end else begin
          blk_all_d[w][8*l +: 8] = '0;
        end
      end
    end
    if ((state_q == ST_LEN) || (pos < LEN_SPLIT_POS)) begin
      blk_all_d[14] = bit_len[31:0];
      blk_all_d[15] = bit_len[63:32];
    end
  end

  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    work_d      = work_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    out_idx_d   = out_idx_q;
    end_pend_d  = end_pend_q;
    len_pend_d  = len_pend_q;
    fin_d       = fin_q;
    blk_we_byte = 1'b0;
    blk_we_all  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          end_pend_d = in_i.end_of_message;
          if (in_i.byte_present) begin
            blk_we_byte = 1'b1;
            cnt_d       = cnt_q + count_t'(1);
          end
          if (in_i.byte_present && (pos == LAST_ROUND)) begin
            work_d  = chain_q;
            rnd_d   = '0;
            state_d = ST_ROUND;
          end else if (in_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        work_d[0] = work_q[3];
        work_d[1] = new_b;
        work_d[2] = work_q[1];
        work_d[3] = work_q[2];
        rnd_d     = rnd_q + round_t'(1);
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int k = 0; k < 4; k++) begin
          chain_d[k] = chain_q[k] + work_q[k];
        end
        if (fin_q) begin
          fin_d     = 1'b0;
          out_idx_d = '0;
          state_d   = ST_OUT;
        end else if (len_pend_q) begin
          state_d = ST_LEN;
        end else if (end_pend_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        blk_we_all = 1'b1;
        end_pend_d = 1'b0;
        if (pos < LEN_SPLIT_POS) begin
          fin_d = 1'b1;
        end else begin
          len_pend_d = 1'b1;
        end
        work_d  = chain_q;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_LEN: begin
        blk_we_all = 1'b1;
        len_pend_d = 1'b0;
        fin_d      = 1'b1;
        work_d     = chain_q;
        rnd_d      = '0;
        state_d    = ST_ROUND;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (out_idx_q == LAST_WORD) begin
            chain_d = INIT_CHAIN;
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + digest_idx_t'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      chain_q    <= INIT_CHAIN;
      work_q     <= '{default: '0};
      cnt_q      <= '0;
      rnd_q      <= '0;
      out_idx_q  <= '0;
      end_pend_q <= 1'b0;
      len_pend_q <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      chain_q    <= chain_d;
      work_q     <= work_d;
      cnt_q      <= cnt_d;
      rnd_q      <= rnd_d;
      out_idx_q  <= out_idx_d;
      end_pend_q <= end_pend_d;
      len_pend_q <= len_pend_d;
      fin_q      <= fin_d;
    end
  end

  // The block store has no reset: every byte is written or padded before use.
  always_ff @(posedge clk_i) begin
    if (blk_we_all) begin
      block_q <= blk_all_d;
    end else if (blk_we_byte) begin
      block_q[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= in_i.data_byte;
    end
  end

  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ROUND) |-> (rnd_q == '0))
    else $error("Round counter is not zero outside a compression.");

  a_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) && (rnd_q == LAST_ROUND) |=> (state_q == ST_ADD))
    else $error("Compression did not end after the last round.");

  a_pend_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_pend_q |-> !end_pend_q) and (fin_q |-> (!len_pend_q && !end_pend_q)))
    else $error("Padding flags are set together.");

  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (out_idx_q != LAST_WORD) |=>
      (out_o.valid && (out_idx_q == $past(out_idx_q) + digest_idx_t'(1))))
    else $error("Digest words are not delivered in order.");

  a_msg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (out_idx_q == LAST_WORD) |=>
      ((cnt_q == '0) && (chain_q[0] == INIT_CHAIN[0]) && (state_q == ST_IDLE)))
    else $error("Block did not return to its initial state after the digest.");

endmodule
